// ----- rtl/ucf_pkg.sv -----
// shared types and constants for the unicode code point filter
`default_nettype none

package ucf_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [1:0] CFG_NL_KEEP     = 2'd1;

  // filter modes (mode 3 acts as controls only)
  localparam logic [1:0] MODE_FULL      = 2'd0;
  localparam logic [1:0] MODE_INVISIBLE = 2'd1;
  localparam logic [1:0] MODE_CONTROLS  = 2'd2;

  // utf-8 continuation byte prefix
  localparam logic [1:0] CONT_PREFIX = 2'b10;

  // highest valid code point
  localparam logic [20:0] CP_MAX = 21'h10FFFF;

  // encoded code point: bytes in send order, count of bytes after the first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      rem;
  } enc_t;

endpackage

`default_nettype wire

// ----- rtl/unicode_codepoint_filter_top.sv -----
// unicode code point filter with utf-8 encoder, one code point per item
// path: an accepted item is held in the input register, then in the output byte register that drives out_byte
// throughput: one item per cycle for one-byte encodings while out_stall is low; a multi-byte encoding
//   holds the output register until its last byte is sent, a dropped item costs one input slot
// set by the output byte register, which sends one byte per cycle while out_stall is low
// reset: synchronous, clears both stages, filter_mode 0, newline keep 1
`default_nettype none

module unicode_codepoint_filter_top
  import ucf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [20:0] code_point,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [1:0]  filter_mode;
  logic        nl_keep;

  logic        s1_valid;
  logic [20:0] s1_cp;
  logic        s1_drop;
  logic        s1_free;

  logic        s2_valid;
  enc_t        s2_enc;
  enc_t        enc_next;
  logic        s2_can_take;
  logic        s2_load;
  logic        out_fire;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_FULL;
      nl_keep     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_MODE: filter_mode <= cfg_data[1:0];
        CFG_NL_KEEP:     nl_keep     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // drop decision on the registered code point
  always_comb begin
    logic is_ctrl;
    logic is_nl;
    logic is_invis;
    logic is_sanitize;
    is_nl    = nl_keep && (s1_cp inside {21'h09, 21'h0A, 21'h0D});
    is_ctrl  = !is_nl && (s1_cp inside {[21'h00 : 21'h1F], [21'h7F : 21'h9F]});
    is_invis = s1_cp inside {21'h00AD, [21'h200B : 21'h200F], [21'h202A : 21'h202E],
                             21'h2060, [21'h2066 : 21'h2069], 21'hFEFF};
    is_sanitize = (s1_cp inside {[21'hD800 : 21'hDFFF], [21'hFDD0 : 21'hFDEF],
                                 [21'hE000 : 21'hF8FF], [21'hF0000 : 21'hFFFFD],
                                 [21'h100000 : 21'h10FFFD], 21'hFFFD})
               || (s1_cp[15:0] == 16'hFFFE) || (s1_cp[15:0] == 16'hFFFF);
    s1_drop = (s1_cp > CP_MAX) || is_ctrl;
    if (filter_mode == MODE_FULL || filter_mode == MODE_INVISIBLE) begin
      s1_drop = s1_drop || is_invis;
    end
    if (filter_mode == MODE_FULL) begin
      s1_drop = s1_drop || is_sanitize;
    end
  end

  // utf-8 encoding of the registered code point
  always_comb begin
    enc_next.bytes = '0;
    if (s1_cp < 21'h80) begin
      enc_next.bytes[0] = s1_cp[7:0];
      enc_next.rem      = 2'd0;
    end else if (s1_cp < 21'h800) begin
      enc_next.bytes[0] = {3'b110, s1_cp[10:6]};
      enc_next.bytes[1] = {CONT_PREFIX, s1_cp[5:0]};
      enc_next.rem      = 2'd1;
    end else if (s1_cp < 21'h10000) begin
      enc_next.bytes[0] = {4'b1110, s1_cp[15:12]};
      enc_next.bytes[1] = {CONT_PREFIX, s1_cp[11:6]};
      enc_next.bytes[2] = {CONT_PREFIX, s1_cp[5:0]};
      enc_next.rem      = 2'd2;
    end else begin
      enc_next.bytes[0] = {5'b11110, s1_cp[20:18]};
      enc_next.bytes[1] = {CONT_PREFIX, s1_cp[17:12]};
      enc_next.bytes[2] = {CONT_PREFIX, s1_cp[11:6]};
      enc_next.bytes[3] = {CONT_PREFIX, s1_cp[5:0]};
      enc_next.rem      = 2'd3;
    end
  end

  // flow control between the stages
  assign out_fire    = s2_valid && !out_stall;
  assign s2_can_take = !s2_valid || (out_fire && s2_enc.rem == 2'd0);
  assign s2_load     = s1_valid && !s1_drop && s2_can_take;
  assign s1_free     = !s1_valid || s1_drop || s2_can_take;
  assign in_stall    = !s1_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_cp <= code_point;
    end
  end

  // output byte register, shifts one byte out each time a non-final byte is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (out_fire && s2_enc.rem == 2'd0) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_enc <= enc_next;
    end else if (out_fire && s2_enc.rem != 2'd0) begin
      s2_enc.bytes <= {8'h00, s2_enc.bytes[3:1]};
      s2_enc.rem   <= s2_enc.rem - 2'd1;
    end
  end

  assign out_valid = s2_valid;
  assign out_byte  = s2_enc.bytes[0];
  assign last_byte = (s2_enc.rem == 2'd0);

endmodule

`default_nettype wire

// ----- rtl/ucf_checker.sv -----
// port-level checks for the unicode code point filter, bound to the top level
`default_nettype none

module ucf_checker
  import ucf_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       last_byte
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("stalled output item changed");

  // a byte that is not the last is a lead or continuation byte
  a_multi_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |-> out_byte[7])
    else $error("non-final byte below 0x80");

  // after a non-final byte the next byte follows at once as a continuation
  a_cont_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_byte |=> out_valid && out_byte[7:6] == CONT_PREFIX)
    else $error("missing continuation byte");

  // a new encoding never starts with a continuation byte
  a_no_stray_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_byte |=> !out_valid || out_byte[7:6] != CONT_PREFIX)
    else $error("encoding starts with a continuation byte");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind unicode_codepoint_filter_top ucf_checker u_ucf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .last_byte (last_byte)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for the unicode code point filter: byte scoreboard, stimulus and checks
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ucf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 43;
  localparam int unsigned EDGE_COUNT    = 27;

  // unused mode value, acts as controls only
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // one expected byte of an encoding
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  // predicts utf-8 bytes per accepted code point and checks them in order
  class utf8_scoreboard;
    logic [1:0]  mode;
    logic        keep_nl;
    utf8_byte_t  bytes_due[$];
    int unsigned failures;

    function new();
      mode     = MODE_FULL;
      keep_nl  = 1'b1;
      failures = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      if (idx == CFG_FILTER_MODE) begin
        mode = val[1:0];
      end else if (idx == CFG_NL_KEEP) begin
        keep_nl = val[0];
      end
    endfunction

    function void note_code_point(logic [20:0] cp);
      logic       newline;
      logic       ctrl;
      logic       invisible;
      logic       reserved;
      logic [7:0] enc [4];
      int         n;
      utf8_byte_t due;
      // beyond unicode is dropped in every mode
      if (cp > CP_MAX) return;
      newline   = keep_nl && (cp == 21'h09 || cp == 21'h0A || cp == 21'h0D);
      ctrl      = !newline && (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F));
      invisible = cp == 21'hAD || (cp >= 21'h200B && cp <= 21'h200F)
                  || (cp >= 21'h202A && cp <= 21'h202E) || cp == 21'h2060
                  || (cp >= 21'h2066 && cp <= 21'h2069) || cp == 21'hFEFF;
      // surrogates, noncharacters, private use and the replacement char
      reserved  = (cp >= 21'hD800 && cp <= 21'hDFFF)
                  || (cp >= 21'hFDD0 && cp <= 21'hFDEF) || cp[15:1] == 15'h7FFF
                  || (cp >= 21'hE000 && cp <= 21'hF8FF)
                  || (cp >= 21'hF0000 && cp <= 21'hFFFFD)
                  || (cp >= 21'h100000 && cp <= 21'h10FFFD) || cp == 21'hFFFD;
      if (ctrl) return;
      if (invisible && (mode == MODE_FULL || mode == MODE_INVISIBLE)) return;
      if (reserved && mode == MODE_FULL) return;
      // utf-8 encoding, surrogates kept outside full mode take three bytes
      if (cp < 21'h80) begin
        enc[0] = cp[7:0];
        n = 1;
      end else if (cp < 21'h800) begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {CONT_PREFIX, cp[5:0]};
        n = 2;
      end else if (cp < 21'h10000) begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {CONT_PREFIX, cp[11:6]};
        enc[2] = {CONT_PREFIX, cp[5:0]};
        n = 3;
      end else begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {CONT_PREFIX, cp[17:12]};
        enc[2] = {CONT_PREFIX, cp[11:6]};
        enc[3] = {CONT_PREFIX, cp[5:0]};
        n = 4;
      end
      for (int k = 0; k < n; k++) begin
        due.data  = enc[k];
        due.last  = (k == n - 1);
        bytes_due = {bytes_due, due};
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      utf8_byte_t want;
      if (bytes_due.size() == 0) begin
        $error("out_byte %h arrived with no byte pending", data);
        failures++;
        return;
      end
      want = bytes_due.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %h, actual %h", want.data, data);
        failures++;
      end
      if (last !== want.last) begin
        $error("last_byte: expected %b, actual %b", want.last, last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return bytes_due.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [20:0] code_point = '0;
  logic        out_valid;
  logic        out_stall  = 1'b1;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;

  int unsigned stall_pct     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  utf8_scoreboard sb;

  unicode_codepoint_filter_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_point (code_point),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // output byte monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_byte(out_byte, last_byte);
    end
  end

  // receiver stalls: random, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // boundary code points of every class
  function automatic logic [20:0] edge_code_point(int unsigned k);
    case (k)
      0:       return 21'h000000;
      1:       return 21'h000009;
      2:       return 21'h00000A;
      3:       return 21'h00000D;
      4:       return 21'h00001F;
      5:       return 21'h000020;
      6:       return 21'h00007F;
      7:       return 21'h00009F;
      8:       return 21'h0000A0;
      9:       return 21'h0000AD;
      10:      return 21'h0007FF;
      11:      return 21'h000800;
      12:      return 21'h00200B;
      13:      return 21'h00202E;
      14:      return 21'h002069;
      15:      return 21'h00D800;
      16:      return 21'h00DFFF;
      17:      return 21'h00F8FF;
      18:      return 21'h00FDD0;
      19:      return 21'h00FEFF;
      20:      return 21'h00FFFD;
      21:      return 21'h00FFFF;
      22:      return 21'h010000;
      23:      return 21'h10FFFD;
      24:      return 21'h10FFFF;
      25:      return 21'h110000;
      default: return 21'h1FFFFF;
    endcase
  endfunction

  // offer one code point, with random idle cycles ahead of it
  task automatic send_code_point(input logic [20:0] cp);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    code_point <= cp;
    do @(posedge clk); while (in_stall);
    sb.note_code_point(cp);
  endtask

  // stop sending and let every pending byte and any dropped item pass
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back
  task automatic write_config(input logic [1:0] mode, input logic keep_nl);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FILTER_MODE;
    cfg_data  <= {6'b0, mode};
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_FILTER_MODE, {6'b0, mode});
    cfg_index <= CFG_NL_KEEP;
    cfg_data  <= {7'b0, keep_nl};
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_NL_KEEP, {7'b0, keep_nl});
    cfg_valid <= 1'b0;
  endtask

  // one configuration with random code points of mixed classes
  task automatic run_phase(input logic [1:0] mode, input logic keep_nl,
                           input int unsigned idle_pct, input int unsigned stall,
                           input bit long_hold);
    logic [20:0] cp;
    int unsigned pick;
    wait_drained();
    write_config(mode, keep_nl);
    send_idle_pct = idle_pct;
    stall_pct <= stall;
    if (long_hold) hold_requests <= hold_requests + 1;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // sender pause until all bytes are out
      if (long_hold && i == PHASE_ITEMS / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 30) begin
        cp = 21'($urandom_range(21'h7F));
      end else if (pick < 40) begin
        cp = 21'($urandom_range(21'h7FF, 21'h80));
      end else if (pick < 60) begin
        cp = 21'(edge_code_point($urandom_range(EDGE_COUNT - 1)) + $urandom_range(4) - 2);
      end else if (pick < 75) begin
        cp = 21'($urandom_range(21'hFFFF, 21'h800));
      end else if (pick < 90) begin
        cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
        // plane noncharacters
        if ($urandom_range(3) == 0) cp[15:1] = 15'h7FFF;
      end else if (pick < 95) begin
        cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
      end else begin
        cp = 21'($urandom);
      end
      send_code_point(cp);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed boundaries under the reset configuration
    for (int k = 0; k < EDGE_COUNT; k++) begin
      send_code_point(edge_code_point(k));
    end
    run_phase(MODE_FULL,      1'b0, 0,  0,  1'b0);
    run_phase(MODE_INVISIBLE, 1'b1, 69, 0,  1'b0);
    run_phase(MODE_CONTROLS,  1'b0, 0,  69, 1'b0);
    run_phase(MODE_UNUSED,    1'b1, 36, 36, 1'b0);
    run_phase(MODE_INVISIBLE, 1'b0, 36, 36, 1'b1);
    run_phase(MODE_FULL,      1'b1, 0,  0,  1'b0);
    run_phase(MODE_CONTROLS,  1'b1, 69, 0,  1'b0);
    run_phase(MODE_UNUSED,    1'b0, 0,  69, 1'b0);
    wait_drained();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
